>>> sv/ltpc_pkg.sv
// ----------------------------------------------------------------------------
// ltpc_pkg
// Shared types and constants of the link test pattern checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ltpc_pkg;

   // action codes of a request word
   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_RX_BYTE = 2'd1;
   localparam logic [1:0] ACT_TX_PKT  = 2'd2;

   // csr register indexes
   localparam logic CSR_TIMEOUT_LIMIT = 1'b0;
   localparam logic CSR_SLAVE_ROLE    = 1'b1;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 25;
   localparam int WAIT_W     = 25;
   localparam int STAT_W     = 32;
   localparam int NUM_STATS  = 8;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 264;

   // widest error byte increment: a whole chunk of up to 256 bytes
   localparam int ERR_ADD_W = 9;

   localparam logic [WAIT_W-1:0] TIMEOUT_RESET = 25'd2133;
   localparam logic [STAT_W-1:0] PKT_BYTES     = 32'd256;

   // counter slots in result order
   localparam int S_TXB = 0;
   localparam int S_RXB = 1;
   localparam int S_TXP = 2;
   localparam int S_RXP = 3;
   localparam int S_ERB = 4;
   localparam int S_ERP = 5;
   localparam int S_LOB = 6;
   localparam int S_LOP = 7;

   // one request word held in the input register
   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
      logic       last_in_chunk;
   } ltpc_req_type;

   // counter updates caused by one request word
   typedef struct packed {
      logic                 tx_pkt;
      logic                 rx_byte;
      logic                 rx_pkt;
      logic [ERR_ADD_W-1:0] err_add;
      logic                 err_pkt;
      logic                 lost;
      logic                 reply;
   } ltpc_event_type;

endpackage

`default_nettype wire

>>> sv/ltpc_in_stage.sv
// ----------------------------------------------------------------------------
// ltpc_in_stage
// Input register of the request stream; holds one word while the result
// register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ltpc_in_stage (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [ltpc_pkg::REQ_DATA_W-1:0]     req_tdata,   // data_byte
   input  wire  [ltpc_pkg::REQ_USER_W-1:0]     req_tuser,   // action
   input  wire                                 req_tlast,   // last_in_chunk
   input  wire                                 advance,
   output logic                                hold_valid,
   output ltpc_pkg::ltpc_req_type              hold_word
);
   import ltpc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   ltpc_req_type word_ff;
   logic         take;

   // accept when empty or when the held word moves on this cycle
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign valid_in   = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (take) begin
         word_ff.action        <= req_tuser;
         word_ff.data_byte     <= req_tdata;
         word_ff.last_in_chunk <= req_tlast;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_word  = word_ff;

endmodule

`default_nettype wire

>>> sv/ltpc_engine.sv
// ----------------------------------------------------------------------------
// ltpc_engine
// Pattern lock, chunk tracking, wait timer and csr registers; turns one
// request word into a set of counter updates.
// ----------------------------------------------------------------------------
`default_nettype none

module ltpc_engine #(
   parameter int CHUNK_BYTES = 256
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_we,
   input  wire  [ltpc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire  [ltpc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire                                 advance,
   input  ltpc_pkg::ltpc_req_type              word,
   output ltpc_pkg::ltpc_event_type            evt
);
   import ltpc_pkg::*;

   localparam int CNT_W = $clog2(CHUNK_BYTES + 1);
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

   logic [WAIT_W-1:0] limit_ff;
   logic              slave_ff;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  expect_ff, expect_in;
   logic              locked_ff, locked_in;
   logic              bad_ff, bad_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;

   logic [WAIT_W-1:0] wait_inc;
   logic              timeout;
   logic              locked_now;
   logic              compare;
   logic              mismatch;
   logic              chunk_end;
   logic [CNT_W-1:0]  count;
   logic              bad_now;
   logic              reply;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TIMEOUT_RESET;
         slave_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_TIMEOUT_LIMIT: limit_ff <= csr_wdata[WAIT_W-1:0];
            CSR_SLAVE_ROLE:    slave_ff <= csr_wdata[0];
            default:           ;
         endcase
      end
   end

   // tick timer, saturating
   assign wait_inc = (wait_ff != {WAIT_W{1'b1}}) ? wait_ff + 1'b1 : wait_ff;
   assign timeout  = wait_inc > limit_ff;

   // pattern compare of a received byte
   assign locked_now = locked_ff || (word.data_byte == 8'h00);
   assign compare    = locked_now && (expect_ff < CNT_W'(CHUNK_BYTES));
   assign mismatch   = compare && (CMP_W'(word.data_byte) != CMP_W'(expect_ff));
   assign chunk_end  = word.last_in_chunk || (pos_ff >= CNT_W'(CHUNK_BYTES - 1));
   assign count      = pos_ff + 1'b1;
   assign bad_now    = bad_ff || mismatch || !locked_now;
   assign reply      = slave_ff && (count >= CNT_W'(CHUNK_BYTES - 1));

   // counter updates and next state
   always_comb begin
      evt       = '0;
      pos_in    = pos_ff;
      expect_in = expect_ff;
      locked_in = locked_ff;
      bad_in    = bad_ff;
      wait_in   = wait_ff;
      unique case (word.action)
         ACT_TICK: begin
            wait_in = timeout ? '0 : wait_inc;
            evt.lost    = timeout;
            evt.err_pkt = timeout;
         end
         ACT_RX_BYTE: begin
            wait_in     = '0;
            evt.rx_byte = 1'b1;
            evt.rx_pkt  = (CMP_W'(pos_ff) == CMP_W'(8'hFF)) && (word.data_byte == 8'hFF);
            if (mismatch) begin
               evt.err_add = ERR_ADD_W'(1);
            end else if (chunk_end && !locked_now) begin
               evt.err_add = ERR_ADD_W'(count);
            end
            if (chunk_end) begin
               evt.err_pkt = bad_now;
               evt.reply   = reply;
               evt.tx_pkt  = reply;
               pos_in      = '0;
               expect_in   = '0;
               locked_in   = 1'b0;
               bad_in      = 1'b0;
            end else begin
               pos_in    = count;
               expect_in = compare ? expect_ff + 1'b1 : expect_ff;
               locked_in = locked_now;
               bad_in    = bad_ff || mismatch;
            end
         end
         ACT_TX_PKT: begin
            if (!slave_ff) begin
               evt.tx_pkt = 1'b1;
               wait_in    = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         expect_ff <= '0;
         locked_ff <= 1'b0;
         bad_ff    <= 1'b0;
         wait_ff   <= '0;
      end else if (advance) begin
         pos_ff    <= pos_in;
         expect_ff <= expect_in;
         locked_ff <= locked_in;
         bad_ff    <= bad_in;
         wait_ff   <= wait_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/ltpc_stats.sv
// ----------------------------------------------------------------------------
// ltpc_stats
// Statistics counters and result register; the counters themselves form
// the data of the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ltpc_stats (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    hold_valid,
   input  ltpc_pkg::ltpc_event_type               evt,
   output logic                                   advance,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [ltpc_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import ltpc_pkg::*;

   logic                              valid_ff, valid_in;
   logic [NUM_STATS-1:0][STAT_W-1:0]  stats_ff, stats_in;
   logic                              reply_ff;
   logic                              tout_ff;

   // result register moves when empty or being taken
   assign advance  = hold_valid && (!valid_ff || rsp_tready);
   assign valid_in = advance || (valid_ff && !rsp_tready);

   // counter increments
   always_comb begin
      stats_in        = stats_ff;
      stats_in[S_TXB] = stats_ff[S_TXB] + (evt.tx_pkt ? PKT_BYTES : '0);
      stats_in[S_RXB] = stats_ff[S_RXB] + STAT_W'(evt.rx_byte);
      stats_in[S_TXP] = stats_ff[S_TXP] + STAT_W'(evt.tx_pkt);
      stats_in[S_RXP] = stats_ff[S_RXP] + STAT_W'(evt.rx_pkt);
      stats_in[S_ERB] = stats_ff[S_ERB] + STAT_W'(evt.err_add);
      stats_in[S_ERP] = stats_ff[S_ERP] + STAT_W'(evt.err_pkt);
      stats_in[S_LOB] = stats_ff[S_LOB] + (evt.lost ? PKT_BYTES : '0);
      stats_in[S_LOP] = stats_ff[S_LOP] + STAT_W'(evt.lost);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         stats_ff <= '0;
         reply_ff <= 1'b0;
         tout_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            stats_ff <= stats_in;
            reply_ff <= evt.reply;
            tout_ff  <= evt.lost;
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'b0, tout_ff, reply_ff, stats_ff};

endmodule

`default_nettype wire

>>> sv/link_test_pattern_checker.sv
// ----------------------------------------------------------------------------
// link_test_pattern_checker
// Incrementing byte pattern checker with link statistics.
// ----------------------------------------------------------------------------
// One request word is taken every clock cycle while the result port is not
// stalled, since each word needs only compares and counter increments; its
// result word passes through the input register and then the counter bank,
// which doubles as the result register, before it reaches the result port.
// Each result carries all eight statistics after that word plus the reply
// and timeout flags. A stalled result port holds one result and one pending
// request; the request side stalls only when both are full. csr writes
// belong to idle periods.
`default_nettype none

module link_test_pattern_checker #(
   parameter int CHUNK_BYTES = 256
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request stream
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [ltpc_pkg::REQ_DATA_W-1:0]     req_tdata,  // data_byte
   input  wire  [ltpc_pkg::REQ_USER_W-1:0]     req_tuser,  // action
   input  wire                                 req_tlast,  // last_in_chunk
   // result stream
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // tx_bytes, rx_bytes, tx_packets, rx_packets, err_bytes, err_packets,
   // lost_bytes, lost_packets (32 bits each), reply_due, timed_out
   output logic [ltpc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // csr write port
   input  wire                                 csr_we,
   input  wire  [ltpc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire  [ltpc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ltpc_pkg::*;

   logic           advance;
   logic           hold_valid;
   ltpc_req_type   hold_word;
   ltpc_event_type evt;

   // input register
   ltpc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_word  (hold_word)
   );

   // pattern and timer logic
   ltpc_engine #(
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .word      (hold_word),
      .evt       (evt)
   );

   // counters and result register
   ltpc_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .hold_valid (hold_valid),
      .evt        (evt),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> sv/ltpc_checker.sv
// ----------------------------------------------------------------------------
// ltpc_checker
// Port level assertions of the link test pattern checker.
// ----------------------------------------------------------------------------
`default_nettype none

module ltpc_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [263:0] rsp_tdata
);

   // a stalled result word keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // reply and timeout come from different actions
   a_flags_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[256] && rsp_tdata[257]))
      else $error("reply and timeout in one word");

   // request side stalls only behind a full result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled with result side free");

   // reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

endmodule

bind link_test_pattern_checker ltpc_checker u_ltpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
